@@ sv/dgini_pkg.sv @@
`timescale 1ns / 1ps
package dgini_pkg;
  localparam int QW = 32;
  localparam int FW = 16;
  localparam int DEF_MAX_LEVELS = 128;
  localparam logic [7:0] LEVELS_RESET = 8'd10;

  typedef struct packed {
    logic [QW-1:0] bid_quantity;
    logic [QW-1:0] ask_quantity;
  } in_t;

  typedef struct packed {
    logic [FW-1:0] gini_fraction;
    logic          empty_book;
  } out_t;
endpackage

@@ sv/dgini_mem.sv @@
`timescale 1ns / 1ps
module dgini_mem import dgini_pkg::*; #(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [QW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [QW-1:0] rdata
);
  logic [QW-1:0] mem [2**AW];
  logic [QW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ sv/dgini_div.sv @@
`timescale 1ns / 1ps
module dgini_div import dgini_pkg::*; #(
  parameter int DW = 56
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [FW-1:0] quo
);
  localparam int KW = $clog2(FW + 1);
  logic [DW-1:0] rem_r, rem_nxt;
  logic [FW-1:0] q_r, q_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          run_r, run_nxt, done_r, done_nxt;
  logic [DW:0]   sh;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    k_nxt    = k_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    sh       = {rem_r, 1'b0};
    if (start) begin
      rem_nxt = num;
      q_nxt   = '0;
      k_nxt   = KW'(FW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (sh >= {1'b0, den}) begin
        rem_nxt = DW'(sh - {1'b0, den});
        q_nxt   = {q_r[FW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DW-1:0];
        q_nxt   = {q_r[FW-2:0], 1'b0};
      end
      k_nxt = k_r - 1'b1;
      if (k_r == KW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

@@ sv/order_book_depth_gini_top.sv @@
`timescale 1ns / 1ps
// channel | ports                               | handshake
// in      | start, busy, in_data                | beat when start & !busy
// out     | out_strobe, out_data                | one-cycle strobe, no stall
// cfg     | cfg_valid, cfg_ready, cfg_data      | beat when valid & ready
// An item sweeps every stored value of the snapshot through the single memory
// read port. Unless the book is empty, the closing level then runs the S_DEN
// and S_NUM multiply states and the divider. Reset is synchronous; the memory
// needs no clearing. Results cannot be stalled.
module order_book_depth_gini_top import dgini_pkg::*; #(
  parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  output logic       out_strobe,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  localparam int AW = $clog2(2 * MAX_LEVELS);
  localparam int CW = $clog2(MAX_LEVELS + 1);
  localparam int TW = QW + CW + 1;
  localparam int DW = TW + CW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_WRB   = 3'd2;
  localparam logic [2:0] S_WRA   = 3'd3;
  localparam logic [2:0] S_DEN   = 3'd4;
  localparam logic [2:0] S_NUM   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;

  logic [2:0]    st_r, st_nxt;
  logic [7:0]    lu_r;
  logic [CW-1:0] cnt_r, cnt_nxt, eff;
  logic [TW-1:0] tot_r, tot_nxt;
  logic [DW-1:0] ps_r, ps_nxt, den_r, den_nxt, num_r, num_nxt;
  logic [QW-1:0] bid_r, ask_r, bid_nxt, ask_nxt;
  logic [CW:0]   a_r, a_nxt, lim, n2;
  logic          pend_r, pend_nxt;
  logic          ostb_r, ostb_nxt;
  out_t          out_r, out_nxt;
  logic          we, div_done;
  logic          div_kick_r;
  logic [AW-1:0] waddr;
  logic [QW-1:0] wdata, rdata, mb, ma, mba;
  logic [FW-1:0] div_q;

  assign lim = {cnt_r, 1'b0};
  assign n2  = lim;

  always_comb begin
    if (lu_r == 8'd0) eff = CW'(1);
    else if (32'(lu_r) > 32'(MAX_LEVELS)) eff = CW'(MAX_LEVELS);
    else eff = CW'(lu_r);
  end

  assign mb  = (rdata < bid_r) ? rdata : bid_r;
  assign ma  = (rdata < ask_r) ? rdata : ask_r;
  assign mba = (in_data.bid_quantity < in_data.ask_quantity) ?
               in_data.bid_quantity : in_data.ask_quantity;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    tot_nxt   = tot_r;
    ps_nxt    = ps_r;
    den_nxt   = den_r;
    num_nxt   = num_r;
    bid_nxt   = bid_r;
    ask_nxt   = ask_r;
    a_nxt     = a_r;
    pend_nxt  = 1'b0;
    ostb_nxt  = 1'b0;
    out_nxt   = out_r;
    we        = 1'b0;
    waddr     = lim[AW-1:0];
    wdata     = bid_r;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          bid_nxt = in_data.bid_quantity;
          ask_nxt = in_data.ask_quantity;
          tot_nxt = tot_r + TW'(in_data.bid_quantity) + TW'(in_data.ask_quantity);
          ps_nxt  = ps_r + DW'(mba);
          a_nxt   = '0;
          st_nxt  = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (pend_r) ps_nxt = ps_r + DW'(mb) + DW'(ma);
        if (a_r < lim) begin
          pend_nxt = 1'b1;
          a_nxt    = a_r + 1'b1;
        end else begin
          st_nxt = S_WRB;
        end
      end
      S_WRB: begin
        we     = 1'b1;
        st_nxt = S_WRA;
      end
      S_WRA: begin
        we      = 1'b1;
        waddr   = lim[AW-1:0] | AW'(1);
        wdata   = ask_r;
        cnt_nxt = cnt_r + 1'b1;
        st_nxt  = S_IDLE;
        if (cnt_nxt >= eff) begin
          if (tot_r == '0) begin
            out_nxt.gini_fraction = '0;
            out_nxt.empty_book    = 1'b1;
            ostb_nxt = 1'b1;
            cnt_nxt  = '0;
            tot_nxt  = '0;
            ps_nxt   = '0;
          end else begin
            st_nxt = S_DEN;
          end
        end
      end
      S_DEN: begin
        den_nxt = DW'(n2) * DW'(tot_r);
        st_nxt  = S_NUM;
      end
      S_NUM: begin
        num_nxt   = DW'(n2 - 1'b1) * DW'(tot_r) - {ps_r[DW-2:0], 1'b0};
        st_nxt    = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          out_nxt.gini_fraction = div_q;
          out_nxt.empty_book    = 1'b0;
          ostb_nxt = 1'b1;
          cnt_nxt  = '0;
          tot_nxt  = '0;
          ps_nxt   = '0;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      tot_r  <= '0;
      ps_r   <= '0;
      lu_r   <= LEVELS_RESET;
      pend_r <= 1'b0;
      ostb_r <= 1'b0;
      a_r    <= '0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      tot_r  <= tot_nxt;
      ps_r   <= ps_nxt;
      pend_r <= pend_nxt;
      ostb_r <= ostb_nxt;
      a_r    <= a_nxt;
      if (cfg_valid) lu_r <= cfg_data;
    end
    den_r <= den_nxt;
    num_r <= num_nxt;
    bid_r <= bid_nxt;
    ask_r <= ask_nxt;
    out_r <= out_nxt;
  end

  dgini_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_r[AW-1:0]),
    .rdata (rdata)
  );

  dgini_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_kick_r),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) div_kick_r <= 1'b0;
    else div_kick_r <= (st_r == S_NUM);
  end

  assign busy       = (st_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = ostb_r;
  assign out_data   = out_r;
endmodule

@@ sv/dgini_chk.sv @@
`timescale 1ns / 1ps
module dgini_chk import dgini_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input in_t        in_data,
  input logic       out_strobe,
  input out_t       out_data,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [7:0] cfg_data
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after accepted beat");
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result without work");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("back-to-back results");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.empty_book |-> out_data.gini_fraction == '0)
    else $error("empty book with nonzero fraction");
endmodule

bind order_book_depth_gini_top dgini_chk u_chk (.*);

@@ test/tb_order_book_depth_gini_top.sv @@
`timescale 1ns / 1ps
module tb_order_book_depth_gini_top;
  import dgini_pkg::*;

  localparam int MAXL = DEF_MAX_LEVELS;
  localparam int SETTLE = 600;
  localparam int STALL_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_t        in_data = '0;
  logic       out_strobe;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  order_book_depth_gini_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the block
  logic [31:0] qty_mem [2*MAXL];
  int unsigned lvl_cnt;
  logic [63:0] qty_sum;
  logic [7:0]  levels_reg;
  out_t        gini_expected [$];

  int unsigned errors, levels_sent, snapshots_seen, empty_seen, cfg_writes;
  int          idle_pct;
  int unsigned quiet_cycles;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [15:0] q16_ratio(input logic [127:0] num, input logic [127:0] den);
    logic [127:0] r;
    logic [15:0] q;
    r = num;
    q = '0;
    for (int k = 0; k < 16; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  task automatic predict_gini(input in_t d);
    int unsigned slot, eff, n;
    logic [31:0] vals [$];
    logic [127:0] cum, bsum, num, den;
    out_t r;
    slot = (lvl_cnt >= MAXL) ? MAXL - 1 : lvl_cnt;
    qty_mem[2*slot] = d.bid_quantity;
    qty_mem[2*slot+1] = d.ask_quantity;
    lvl_cnt = slot + 1;
    qty_sum = qty_sum + d.bid_quantity + d.ask_quantity;
    eff = (levels_reg == 0) ? 1 : (levels_reg > MAXL ? MAXL : levels_reg);
    if (lvl_cnt < eff) return;
    n = 2 * lvl_cnt;
    r = '0;
    if (qty_sum == 0) begin
      r.empty_book = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) vals.push_back(qty_mem[i]);
      vals.sort();
      cum = '0;
      bsum = '0;
      foreach (vals[i]) begin
        cum = cum + vals[i];
        bsum = bsum + cum;
      end
      num = (n + 1) * 128'(qty_sum) - 2 * bsum;
      den = n * 128'(qty_sum);
      r.gini_fraction = q16_ratio(num, den);
    end
    gini_expected.push_back(r);
    lvl_cnt = 0;
    qty_sum = '0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (gini_expected.size() == 0) begin
        report_mismatch("unexpected result", out_data.gini_fraction, 0);
      end else begin
        if (out_data.gini_fraction !== gini_expected[0].gini_fraction)
          report_mismatch("gini_fraction", out_data.gini_fraction,
                          gini_expected[0].gini_fraction);
        if (out_data.empty_book !== gini_expected[0].empty_book)
          report_mismatch("empty_book", out_data.empty_book, gini_expected[0].empty_book);
        if (gini_expected[0].empty_book) empty_seen++;
        void'(gini_expected.pop_front());
        snapshots_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_level(input logic [31:0] bid, input logic [31:0] ask);
    in_t d;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    d.bid_quantity = bid;
    d.ask_quantity = ask;
    start <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (busy);
    predict_gini(d);
    levels_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (gini_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_levels(input logic [7:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    levels_reg = v;
    cfg_writes++;
  endtask

  function automatic logic [31:0] rand_qty();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(15);
      3: return 32'd1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_default_levels();
    send_level('1, '1);
    send_level('0, '0);
    send_level(32'h8000_0000, 32'd1);
    for (int i = 0; i < 7; i++) send_level(i, 32'hFFFF_FFFF - i);
  endtask

  task automatic test_empty_and_low();
    write_levels(8'd1);
    send_level('0, '0);
    send_level(32'd5, '0);
    send_level('1, '1);
    write_levels(8'd0);
    send_level('0, '0);
    send_level('0, 32'd7);
  endtask

  task automatic test_lowered_mid_snapshot();
    write_levels(8'd8);
    for (int i = 0; i < 5; i++) send_level(rand_qty(), rand_qty());
    write_levels(8'd3);
    send_level(32'd100, 32'd0);
  endtask

  task automatic test_saturated_levels();
    write_levels(8'd255);
    for (int i = 0; i < MAXL; i++) send_level($urandom, $urandom);
    write_levels(8'd128);
    for (int i = 0; i < MAXL; i++) send_level(rand_qty(), rand_qty());
  endtask

  task automatic test_random_snapshots();
    int pcts [3] = '{0, 45, 21};
    int unsigned lv, cnt;
    foreach (pcts[p]) begin
      idle_pct = pcts[p];
      for (int unsigned sent = 0; sent < 300; sent += cnt) begin
        case ($urandom_range(49))
          0: lv = 128;
          1: lv = 0;
          2: lv = 255;
          default: lv = $urandom_range(1, 12);
        endcase
        write_levels(8'(lv));
        lv = (lv == 0) ? 1 : (lv > MAXL ? MAXL : lv);
        cnt = lv * $urandom_range(1, 3) + $urandom_range(0, 2);
        for (int i = 0; i < cnt; i++) send_level(rand_qty(), rand_qty());
      end
      drain_results();
    end
  endtask

  initial begin
    lvl_cnt = 0;
    qty_sum = '0;
    levels_reg = LEVELS_RESET;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_levels();
    test_empty_and_low();
    test_lowered_mid_snapshot();
    test_saturated_levels();
    test_random_snapshots();
    drain_results();
    $display("levels sent %0d, snapshots checked %0d (%0d empty), register writes %0d",
             levels_sent, snapshots_seen, empty_seen, cfg_writes);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
